// ===== hw/rtl/dti_pkg.sv =====
// shared types and constants for the dated table interpolator
`default_nettype none
package dti_pkg;
	localparam int MaxPoints = 64;
	localparam int IdxW = $clog2(MaxPoints);
	localparam int CntW = $clog2(MaxPoints + 1);
	localparam int DayW = 24;
	localparam int RateW = 16;
	localparam int StW = 3;
	localparam logic [RateW-1:0] RateOne = 16'd32768;

	typedef enum logic [StW-1:0] {
		ST_OK = 3'd0,
		ST_BEFORE = 3'd1,
		ST_AFTER = 3'd2,
		ST_EMPTY = 3'd3,
		ST_ORDER = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_NUM = 2'd0,
		CFG_MODE = 2'd1,
		CFG_XB = 2'd2,
		CFG_XA = 2'd3
	} cfg_idx_t;

	localparam logic [1:0] ModeLeft = 2'd1;
	localparam logic [1:0] ModeRight = 2'd2;

	// queued word between front and back
	typedef struct packed {
		logic op;
		logic [IdxW-1:0] idx;
		logic in_range;
		logic [DayW-1:0] day;
		logic [RateW-1:0] rate;
	} cmd_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_LRD, BK_LCHK, BK_RD0, BK_CHK0, BK_RDN, BK_CHKN,
		BK_RDM, BK_CHKM, BK_RDLO, BK_RDHI, BK_MUL, BK_DIV, BK_OUT
	} bk_state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dti_front.sv =====
// front part: takes commands, classifies them, two-entry queue to the back
`default_nettype none
module dti_front import dti_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic op,
	input wire logic [5:0] point_index,
	input wire logic [DayW-1:0] day_number,
	input wire logic [RateW-1:0] rate_in,
	output logic busy,
	output logic cmd_valid,
	output cmd_t cmd,
	input wire logic cmd_pop
);
	cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q;
	logic push;
	cmd_t in_cmd;

	// classify the incoming word
	always_comb begin
		in_cmd.op = op;
		in_cmd.idx = point_index[IdxW-1:0];
		in_cmd.in_range = ({26'd0, point_index} < 32'(MaxPoints));
		in_cmd.day = day_number;
		in_cmd.rate = (rate_in > RateOne) ? RateOne : rate_in;
	end

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
			if (cmd_pop) rd_q <= ~rd_q;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) q_q[rd_q ^ (cnt_q != 2'd0)] <= in_cmd;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/dti_back.sv =====
// back part: table memory, bisection search and interpolation
`default_nettype none
module dti_back import dti_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_pop,
	input wire logic [CntW-1:0] num_pts,
	input wire logic [1:0] mode,
	input wire logic xb,
	input wire logic xa,
	output logic done,
	output logic [RateW-1:0] rate_out,
	output logic [StW-1:0] status
);
	logic [DayW-1:0] dates_q [MaxPoints];
	logic [RateW-1:0] rates_q [MaxPoints];
	logic [DayW-1:0] rd_date_q;
	logic [RateW-1:0] rd_rate_q;

	bk_state_t st_q, st_d;
	cmd_t c_q;
	logic [IdxW-1:0] lo_q, hi_q, nl_q, addr;
	logic [DayW-1:0] dlo_q;
	logic [RateW-1:0] rlo_q, res_q;
	logic [StW-1:0] sts_q;
	logic neg_q;
	logic eq0_q;
	logic lin_q;
	logic out_q;
	logic [DayW+RateW-1:0] rem_q;
	logic [DayW+RateW-1:0] quo_q;
	logic [DayW-1:0] den_q;
	logic [5:0] bit_q;
	logic [IdxW:0] mid_w;
	logic [IdxW-1:0] mid;
	logic [RateW-1:0] diff;
	logic [DayW+RateW:0] trial;
	logic [RateW-1:0] rsum;

	assign mid_w = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_w[IdxW:1];
	assign diff = neg_q ? (rlo_q - rd_rate_q) : (rd_rate_q - rlo_q);
	assign trial = {rem_q, quo_q[DayW+RateW-1]} - {1'b0, 16'd0, den_q};

	// memory address per state, data is seen one state later
	always_comb begin
		case (st_q)
			BK_LRD: addr = c_q.idx - IdxW'(1);
			BK_RD0: addr = '0;
			BK_RDN: addr = nl_q;
			BK_RDM: addr = mid;
			BK_RDLO: addr = lo_q;
			default: addr = hi_q;
		endcase
	end

	// table memory with registered read
	always_ff @(posedge clk) begin
		rd_date_q <= dates_q[addr];
		rd_rate_q <= rates_q[addr];
		if (st_q == BK_LCHK && c_q.in_range) begin
			dates_q[c_q.idx] <= c_q.day;
			rates_q[c_q.idx] <= c_q.rate;
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		cmd_pop = 1'b0;
		case (st_q)
			BK_IDLE: if (cmd_valid) begin
				cmd_pop = 1'b1;
				st_d = cmd.op ? BK_RD0 : BK_LRD;
			end
			BK_LRD: st_d = BK_LCHK;
			BK_LCHK: st_d = BK_OUT;
			BK_RD0: st_d = (num_pts == '0) ? BK_OUT : BK_CHK0;
			BK_CHK0: st_d = (c_q.day < rd_date_q) ? BK_OUT : BK_RDN;
			BK_RDN: st_d = BK_CHKN;
			BK_CHKN: st_d = (c_q.day >= rd_date_q || eq0_q) ? BK_OUT : BK_RDM;
			BK_RDM: st_d = BK_CHKM;
			BK_CHKM: begin
				if (c_q.day == rd_date_q) st_d = BK_OUT;
				else if ((c_q.day < rd_date_q ? mid : hi_q) -
					(c_q.day < rd_date_q ? lo_q : mid) > IdxW'(1)) st_d = BK_RDM;
				else st_d = BK_RDLO;
			end
			BK_RDLO: st_d = BK_RDHI;
			BK_RDHI: st_d = (mode == ModeLeft) ? BK_OUT : BK_MUL;
			BK_MUL: st_d = (mode == ModeRight) ? BK_OUT : BK_DIV;
			BK_DIV: if (bit_q == 6'd0) st_d = BK_OUT;
			BK_OUT: st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else st_q <= st_d;
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			BK_IDLE: begin
				c_q <= cmd;
				res_q <= '0;
				sts_q <= ST_OK;
				lin_q <= 1'b0;
				nl_q <= (num_pts > CntW'(MaxPoints)) ? IdxW'(MaxPoints - 1) :
					IdxW'(num_pts - CntW'(1));
			end
			BK_LRD: ;
			BK_LCHK: if (c_q.in_range && c_q.idx != '0 && c_q.day <= rd_date_q)
				sts_q <= ST_ORDER;
			BK_RD0: if (num_pts == '0) sts_q <= ST_EMPTY;
			BK_CHK0: begin
				lo_q <= '0;
				hi_q <= nl_q;
				eq0_q <= (c_q.day == rd_date_q);
				if (c_q.day < rd_date_q) begin
					if (xb) res_q <= rd_rate_q; else sts_q <= ST_BEFORE;
				end else if (c_q.day == rd_date_q) res_q <= rd_rate_q;
			end
			// after the table wins over a hit on the first date
			BK_CHKN: begin
				if (c_q.day > rd_date_q) begin
					if (xa) res_q <= rd_rate_q;
					else begin
						res_q <= '0;
						sts_q <= ST_AFTER;
					end
				end else if (!eq0_q && c_q.day == rd_date_q) res_q <= rd_rate_q;
			end
			BK_CHKM: begin
				if (c_q.day == rd_date_q) res_q <= rd_rate_q;
				else if (c_q.day < rd_date_q) hi_q <= mid;
				else lo_q <= mid;
			end
			BK_RDHI: begin
				dlo_q <= rd_date_q;
				rlo_q <= rd_rate_q;
				if (mode == ModeLeft) res_q <= rd_rate_q;
			end
			BK_MUL: begin
				// rd holds hi point; span and sign of the rate step
				if (mode == ModeRight) res_q <= rd_rate_q;
				lin_q <= (mode != ModeRight);
				neg_q <= rd_rate_q < rlo_q;
				den_q <= rd_date_q - dlo_q;
				quo_q <= '0;
				rem_q <= '0;
				bit_q <= 6'(DayW + RateW);
			end
			BK_DIV: begin
				if (bit_q == 6'(DayW + RateW)) begin
					quo_q <= 40'(diff) * 40'(c_q.day - dlo_q);
					bit_q <= bit_q - 6'd1;
				end else begin
					if (!trial[DayW+RateW]) begin
						rem_q <= trial[DayW+RateW-1:0];
						quo_q <= {quo_q[DayW+RateW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[DayW+RateW-2:0], quo_q[DayW+RateW-1]};
						quo_q <= {quo_q[DayW+RateW-2:0], 1'b0};
					end
					bit_q <= bit_q - 6'd1;
				end
			end
			BK_OUT: if (lin_q) res_q <= neg_q ? (rlo_q - quo_q[RateW-1:0]) : rsum;
			default: ;
		endcase
	end

	assign rsum = rlo_q + quo_q[RateW-1:0];

	// result strobe is registered from BK_OUT so the fraction lands first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_q <= 1'b0;
		else out_q <= (st_q == BK_OUT);
	end

	assign done = out_q;
	assign rate_out = res_q;
	assign status = sts_q;
endmodule
`default_nettype wire

// ===== hw/rtl/dated_table_interpolator_unit.sv =====
// top level of the dated table interpolator
// done is registered after BK_OUT; a load word passes BK_LRD and BK_LCHK, a query takes
// one read per table end, a read and a check state per bisection step over the registered-read
// table memory, then, in linear mode, a span state, the product and a 40-bit bit-serial divider
// a two-word queue lets start be taken while the back part is at work; one word at a time
// arst_n clears control and config (extrapolation on); table content undefined
`default_nettype none
module dated_table_interpolator_unit import dti_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic op,
	input wire logic [5:0] point_index,
	input wire logic [DayW-1:0] day_number,
	input wire logic [RateW-1:0] rate_in,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [6:0] cfg_data,
	output logic done,
	output logic [RateW-1:0] rate_out,
	output logic [StW-1:0] status
);
	logic [CntW-1:0] num_q;
	logic [1:0] mode_q;
	logic xb_q, xa_q;
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			mode_q <= '0;
			xb_q <= 1'b1;
			xa_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NUM: num_q <= cfg_data[CntW-1:0];
				CFG_MODE: mode_q <= cfg_data[1:0];
				CFG_XB: xb_q <= cfg_data[0];
				CFG_XA: xa_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dti_front u_front (.clk, .arst_n, .start, .op, .point_index, .day_number,
		.rate_in, .busy, .cmd_valid, .cmd, .cmd_pop);

	dti_back u_back (.clk, .arst_n, .cmd_valid, .cmd, .cmd_pop, .num_pts(num_q),
		.mode(mode_q), .xb(xb_q), .xa(xa_q), .done, .rate_out, .status);
endmodule
`default_nettype wire

// ===== hw/rtl/dti_checker.sv =====
// port-level checks for the dated table interpolator
`default_nettype none
module dti_checker import dti_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [RateW-1:0] rate_out,
	input wire logic [StW-1:0] status
);
	a_rate_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rate_out <= RateOne) else $error("rate above one");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK && status != ST_ORDER |-> rate_out == '0)
		else $error("error with rate");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_ORDER) else $error("bad status");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back to back done");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({start, busy, done})) else $error("unknown handshake");
endmodule
bind dated_table_interpolator_unit dti_checker u_chk (.clk, .arst_n, .start, .busy,
	.done, .rate_out, .status);
`default_nettype wire
